>>> rtl/i2cms_pkg.sv
// Package for the I2C master status sequencer: request and result types,
// configuration types, controller status codes and control register bits.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package i2cms_pkg;

   // Default depth of the transmit store.
   localparam int TX_DEPTH_DEFAULT = 8;

   // Field widths fixed by the interface.
   localparam int BYTE_W    = 8;
   localparam int ADDR7_W   = 7;
   localparam int LEN_W     = 4;
   localparam int ENTRY_W   = 3;
   localparam int RX_IDX_W  = 3;
   localparam int RX_CNT_W  = 4;

   // Number of store positions a load request can name.
   localparam int ENTRY_SLOTS = 2 ** ENTRY_W;

   // Saturation value of the receive counter.
   localparam logic [RX_CNT_W-1:0] RX_MAX = 4'd15;

   // Configuration port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0] REG_SLAVE_ADDRESS = 2'd0;
   localparam logic [1:0] REG_READ_MODE     = 2'd1;
   localparam logic [1:0] REG_TX_LENGTH     = 2'd2;
   localparam logic [1:0] REG_RX_LENGTH     = 2'd3;

   // Request kinds.
   localparam logic ACTION_STATUS = 1'b0;
   localparam logic ACTION_LOAD   = 1'b1;

   // Controller control register bits.
   localparam logic [BYTE_W-1:0] BIT_ACK = 8'h04;
   localparam logic [BYTE_W-1:0] BIT_SI  = 8'h08;
   localparam logic [BYTE_W-1:0] BIT_STO = 8'h10;
   localparam logic [BYTE_W-1:0] BIT_STA = 8'h20;

   // Controller status codes.
   localparam logic [BYTE_W-1:0] ST_BUS_ERROR     = 8'h00;
   localparam logic [BYTE_W-1:0] ST_START         = 8'h08;
   localparam logic [BYTE_W-1:0] ST_REP_START     = 8'h10;
   localparam logic [BYTE_W-1:0] ST_ADDR_W_ACK    = 8'h18;
   localparam logic [BYTE_W-1:0] ST_ADDR_W_NACK   = 8'h20;
   localparam logic [BYTE_W-1:0] ST_DATA_TX_ACK   = 8'h28;
   localparam logic [BYTE_W-1:0] ST_DATA_TX_NACK  = 8'h30;
   localparam logic [BYTE_W-1:0] ST_ARB_LOST      = 8'h38;
   localparam logic [BYTE_W-1:0] ST_ADDR_R_ACK    = 8'h40;
   localparam logic [BYTE_W-1:0] ST_ADDR_R_NACK   = 8'h48;
   localparam logic [BYTE_W-1:0] ST_DATA_RX_ACK   = 8'h50;
   localparam logic [BYTE_W-1:0] ST_DATA_RX_NACK  = 8'h58;

   typedef struct packed {
      logic                action;
      logic [BYTE_W-1:0]   status_code;
      logic [BYTE_W-1:0]   bus_data;
      logic [ENTRY_W-1:0]  entry_index;
      logic [BYTE_W-1:0]   entry_value;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   set_mask;
      logic [BYTE_W-1:0]   clear_mask;
      logic                data_valid;
      logic [BYTE_W-1:0]   data_out;
      logic                ack_seen;
      logic                rx_valid;
      logic [BYTE_W-1:0]   rx_byte;
      logic [RX_IDX_W-1:0] rx_index;
   } rsp_type;

   typedef struct packed {
      logic [ADDR7_W-1:0] slave_address;
      logic               read_mode;
      logic [LEN_W-1:0]   tx_length;
      logic [LEN_W-1:0]   rx_length;
   } cfg_type;

endpackage

>>> rtl/i2cms_csr.sv
// Configuration register file of the I2C master status sequencer, APB-style.
// Depends on i2cms_pkg for the register indexes and the cfg_type struct.
`timescale 1ns / 1ps

module i2cms_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [i2cms_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [i2cms_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [i2cms_pkg::CSR_DATA_W-1:0] prdata,
   output logic                             pready,
   output i2cms_pkg::cfg_type               cfg
);
   import i2cms_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_sel;
   logic       wr_en;

   assign reg_sel = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_SLAVE_ADDRESS: cfg_in.slave_address = pwdata[ADDR7_W-1:0];
            REG_READ_MODE:     cfg_in.read_mode     = pwdata[0];
            REG_TX_LENGTH:     cfg_in.tx_length     = pwdata[LEN_W-1:0];
            REG_RX_LENGTH:     cfg_in.rx_length     = pwdata[LEN_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_address <= '0;
         cfg_ff.read_mode     <= 1'b0;
         cfg_ff.tx_length     <= '0;
         cfg_ff.rx_length     <= LEN_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_SLAVE_ADDRESS: prdata = CSR_DATA_W'(cfg_ff.slave_address);
         REG_READ_MODE:     prdata = CSR_DATA_W'(cfg_ff.read_mode);
         REG_TX_LENGTH:     prdata = CSR_DATA_W'(cfg_ff.tx_length);
         REG_RX_LENGTH:     prdata = CSR_DATA_W'(cfg_ff.rx_length);
         default:           prdata = '0;
      endcase
   end

endmodule

>>> rtl/i2c_master_status_sequencer.sv
// A request passes through the input register, then the result register, which
// drives rsp_valid. Throughput: one request per cycle while the result side is
// not stalled; the decode, the store read and the counter updates sit in one stage.
// Load requests and unknown status codes are consumed and give no result.
// Reset is synchronous and active high: counters and valid flags zero, rx_length
// one, other settings zero; the transmit store is not cleared and holds garbage
// until loaded.
`timescale 1ns / 1ps

// Top level of the I2C master status sequencer.
// Depends on i2cms_pkg and instantiates i2cms_csr.
module i2c_master_status_sequencer #(
   parameter int TX_DEPTH = i2cms_pkg::TX_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_valid,
   output logic                             req_stall,
   input  i2cms_pkg::req_type               req_data,
   // Result channel.
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output i2cms_pkg::rsp_type               rsp_data,
   // Configuration port.
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [i2cms_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [i2cms_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [i2cms_pkg::CSR_DATA_W-1:0] prdata,
   output logic                             pready
);
   import i2cms_pkg::*;

   // The transmit counter runs from zero up to TX_DEPTH inclusive. Only the
   // first ENTRY_SLOTS positions can ever be loaded, so only those get storage;
   // positions past the storage read as zero.
   localparam int TCW    = $clog2(TX_DEPTH + 1);
   localparam int CMPW   = (TCW > LEN_W) ? TCW : LEN_W;
   localparam int SDEPTH = (TX_DEPTH < ENTRY_SLOTS) ? TX_DEPTH : ENTRY_SLOTS;
   localparam int SIW    = $clog2(SDEPTH);

   cfg_type cfg;

   i2cms_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Input register.
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // Result register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // Sequencer state.
   logic [TCW-1:0]      tx_count_ff, tx_count_in;
   logic [RX_CNT_W-1:0] rx_count_ff, rx_count_in;
   logic [BYTE_W-1:0]   tx_store_ff [SDEPTH];

   logic                req_take;
   logic                advance;
   logic                step;
   logic                hit;
   logic [BYTE_W-1:0]   store_byte;
   logic [CMPW-1:0]     tx_limit;
   logic                store_wr;

   // The stage moves whenever the result register is empty or being drained.
   // A stalled result holds back a new request only while the input register
   // is also occupied.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign step      = in_valid_ff && advance;

   assign in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   // Transmit store: one write port at the load position, one read at the
   // current transmit position.
   assign store_wr = step && (in_data_ff.action == ACTION_LOAD) &&
                     (ENTRY_W'(0) + {1'b0, in_data_ff.entry_index} < (ENTRY_W+1)'(SDEPTH));

   always_ff @(posedge clock) begin
      if (store_wr) begin
         tx_store_ff[in_data_ff.entry_index[SIW-1:0]] <= in_data_ff.entry_value;
      end
   end

   assign store_byte = (CMPW'(tx_count_ff) < CMPW'(SDEPTH)) ?
                       tx_store_ff[tx_count_ff[SIW-1:0]] : '0;

   // The stop point of the transmit phase is the programmed length, clamped
   // to the depth of the store.
   assign tx_limit = (CMPW'(cfg.tx_length) > CMPW'(TX_DEPTH)) ?
                     CMPW'(TX_DEPTH) : CMPW'(cfg.tx_length);

   // Status decode. Each recognized code yields one result; START and
   // repeated START load the address byte and clear both counters.
   always_comb begin
      hit         = 1'b0;
      rsp_data_in = '0;
      tx_count_in = tx_count_ff;
      rx_count_in = rx_count_ff;
      if (in_data_ff.action == ACTION_STATUS) begin
         hit = 1'b1;
         case (in_data_ff.status_code)
            ST_BUS_ERROR: begin
               rsp_data_in.set_mask   = BIT_STO | BIT_ACK;
               rsp_data_in.clear_mask = BIT_SI;
            end
            ST_START, ST_REP_START: begin
               rsp_data_in.clear_mask = (in_data_ff.status_code == ST_START) ?
                                        (BIT_STA | BIT_SI) : BIT_SI;
               rsp_data_in.data_valid = 1'b1;
               rsp_data_in.data_out   = {cfg.slave_address, cfg.read_mode};
               tx_count_in = '0;
               rx_count_in = '0;
            end
            ST_ADDR_W_ACK: begin
               // The first byte goes out regardless of the programmed length.
               rsp_data_in.ack_seen   = 1'b1;
               rsp_data_in.data_valid = 1'b1;
               rsp_data_in.data_out   = store_byte;
               rsp_data_in.set_mask   = BIT_ACK;
               rsp_data_in.clear_mask = BIT_SI | BIT_STA;
               if (CMPW'(tx_count_ff) < CMPW'(TX_DEPTH)) begin
                  tx_count_in = tx_count_ff + TCW'(1);
               end
            end
            ST_DATA_TX_ACK: begin
               if (CMPW'(tx_count_ff) < tx_limit) begin
                  rsp_data_in.data_valid = 1'b1;
                  rsp_data_in.data_out   = store_byte;
                  rsp_data_in.set_mask   = BIT_ACK;
                  rsp_data_in.clear_mask = BIT_SI | BIT_STA;
                  tx_count_in = tx_count_ff + TCW'(1);
               end else begin
                  rsp_data_in.set_mask   = BIT_STO | BIT_ACK;
                  rsp_data_in.clear_mask = BIT_SI | BIT_STA;
               end
            end
            ST_ADDR_W_NACK, ST_DATA_TX_NACK, ST_ADDR_R_NACK: begin
               rsp_data_in.set_mask   = BIT_STO | BIT_ACK;
               rsp_data_in.clear_mask = BIT_SI | BIT_STA;
            end
            ST_ARB_LOST: begin
               rsp_data_in.set_mask   = BIT_STA | BIT_ACK;
               rsp_data_in.clear_mask = BIT_SI;
            end
            ST_ADDR_R_ACK: begin
               rsp_data_in.set_mask   = BIT_ACK;
               rsp_data_in.clear_mask = BIT_SI | BIT_STA;
            end
            ST_DATA_RX_ACK: begin
               rsp_data_in.rx_valid = 1'b1;
               rsp_data_in.rx_byte  = in_data_ff.bus_data;
               rsp_data_in.rx_index = rx_count_ff[RX_IDX_W-1:0];
               if (rx_count_ff < RX_MAX) begin
                  rx_count_in = rx_count_ff + RX_CNT_W'(1);
               end
               // ACK is returned while at least one more byte is expected
               // after the next one.
               if ({1'b0, rx_count_in} + (RX_CNT_W+1)'(1) <
                   (RX_CNT_W+1)'(cfg.rx_length)) begin
                  rsp_data_in.set_mask   = BIT_ACK;
                  rsp_data_in.clear_mask = BIT_SI | BIT_STA;
               end else begin
                  rsp_data_in.clear_mask = BIT_SI | BIT_ACK | BIT_STA;
               end
            end
            ST_DATA_RX_NACK: begin
               rsp_data_in.rx_valid = 1'b1;
               rsp_data_in.rx_byte  = in_data_ff.bus_data;
               rsp_data_in.rx_index = rx_count_ff[RX_IDX_W-1:0];
               if (rx_count_ff < RX_MAX) begin
                  rx_count_in = rx_count_ff + RX_CNT_W'(1);
               end
               rsp_data_in.set_mask   = BIT_STO | BIT_ACK;
               rsp_data_in.clear_mask = BIT_SI | BIT_STA;
            end
            default: begin
               hit = 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid_in = advance ? (in_valid_ff && hit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         tx_count_ff  <= '0;
         rx_count_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            tx_count_ff <= tx_count_in;
            rx_count_ff <= rx_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The transmit position never runs past the store depth.
   a_tx_count_range: assert property (@(posedge clock) disable iff (reset)
      CMPW'(tx_count_ff) <= CMPW'(TX_DEPTH))
      else $error("transmit counter beyond store depth");

   // A START or repeated START that is processed leaves both counters cleared.
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (step && in_data_ff.action == ACTION_STATUS &&
       (in_data_ff.status_code == ST_START || in_data_ff.status_code == ST_REP_START))
      |=> (tx_count_ff == '0 && rx_count_ff == '0))
      else $error("counters not cleared after START");

   // A result never loads a transmit byte and delivers a received byte at once.
   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.data_valid && rsp_data_ff.rx_valid))
      else $error("result both transmits and receives");

   // The request side is held off only while a request waits in the input stage.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff))
      else $error("request stalled with empty pipeline");

endmodule

>>> verif/i2cms_result_checker.sv
// Result checker for the I2C master status sequencer: watches the request,
// result and configuration ports, predicts each result and compares it.
// Depends on i2cms_pkg for the request, result and configuration types.
`timescale 1ns / 1ps

module i2cms_result_checker #(
   parameter int TX_DEPTH = i2cms_pkg::TX_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  i2cms_pkg::req_type               req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  i2cms_pkg::rsp_type               rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic                             pready,
   input  logic [i2cms_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [i2cms_pkg::CSR_DATA_W-1:0] pwdata,
   output int unsigned                      mismatches,
   output int unsigned                      pending
);
   import i2cms_pkg::*;

   cfg_type           cfg;
   logic [BYTE_W-1:0] tx_image [TX_DEPTH];
   int                tx_pos;
   int                rx_pos;
   rsp_type           awaited_results [$];
   rsp_type           prediction;
   rsp_type           oldest;
   string             diff;
   int unsigned       errors = 0;

   assign mismatches = errors;

   function automatic logic [BYTE_W-1:0] store_byte(input int pos);
      return (pos < TX_DEPTH) ? tx_image[pos] : '0;
   endfunction

   // Advances the sequencer state by one request; returns 1 when it yields a result.
   function automatic bit sequence_status(input req_type rq, output rsp_type rs);
      int tx_limit;
      rs = '0;
      tx_limit = (cfg.tx_length > TX_DEPTH) ? TX_DEPTH : cfg.tx_length;
      if (rq.action == ACTION_LOAD) begin
         if (rq.entry_index < TX_DEPTH)
            tx_image[rq.entry_index] = rq.entry_value;
         return 1'b0;
      end
      case (rq.status_code)
         ST_BUS_ERROR: begin
            rs.set_mask   = BIT_STO | BIT_ACK;
            rs.clear_mask = BIT_SI;
         end
         ST_START, ST_REP_START: begin
            rs.clear_mask = (rq.status_code == ST_START) ? (BIT_STA | BIT_SI) : BIT_SI;
            rs.data_valid = 1'b1;
            rs.data_out   = {cfg.slave_address, cfg.read_mode};
            tx_pos = 0;
            rx_pos = 0;
         end
         ST_ADDR_W_ACK: begin
            rs.ack_seen   = 1'b1;
            rs.data_valid = 1'b1;
            rs.data_out   = store_byte(tx_pos);
            rs.set_mask   = BIT_ACK;
            rs.clear_mask = BIT_SI | BIT_STA;
            if (tx_pos < TX_DEPTH)
               tx_pos++;
         end
         ST_DATA_TX_ACK: begin
            rs.clear_mask = BIT_SI | BIT_STA;
            if (tx_pos < tx_limit) begin
               rs.data_valid = 1'b1;
               rs.data_out   = store_byte(tx_pos);
               rs.set_mask   = BIT_ACK;
               tx_pos++;
            end else begin
               rs.set_mask = BIT_STO | BIT_ACK;
            end
         end
         ST_ADDR_W_NACK, ST_DATA_TX_NACK, ST_ADDR_R_NACK: begin
            rs.set_mask   = BIT_STO | BIT_ACK;
            rs.clear_mask = BIT_SI | BIT_STA;
         end
         ST_ARB_LOST: begin
            rs.set_mask   = BIT_STA | BIT_ACK;
            rs.clear_mask = BIT_SI;
         end
         ST_ADDR_R_ACK: begin
            rs.set_mask   = BIT_ACK;
            rs.clear_mask = BIT_SI | BIT_STA;
         end
         ST_DATA_RX_ACK: begin
            rs.rx_valid = 1'b1;
            rs.rx_byte  = rq.bus_data;
            rs.rx_index = rx_pos[RX_IDX_W-1:0];
            if (rx_pos < RX_MAX)
               rx_pos++;
            // ACK is returned only while more than one byte is still to come.
            if (rx_pos + 1 < cfg.rx_length) begin
               rs.set_mask   = BIT_ACK;
               rs.clear_mask = BIT_SI | BIT_STA;
            end else begin
               rs.clear_mask = BIT_SI | BIT_ACK | BIT_STA;
            end
         end
         ST_DATA_RX_NACK: begin
            rs.rx_valid = 1'b1;
            rs.rx_byte  = rq.bus_data;
            rs.rx_index = rx_pos[RX_IDX_W-1:0];
            if (rx_pos < RX_MAX)
               rx_pos++;
            rs.set_mask   = BIT_STO | BIT_ACK;
            rs.clear_mask = BIT_SI | BIT_STA;
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg = '0;
         cfg.rx_length = LEN_W'(1);
         tx_pos = 0;
         rx_pos = 0;
         awaited_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_SLAVE_ADDRESS: cfg.slave_address = pwdata[ADDR7_W-1:0];
               REG_READ_MODE:     cfg.read_mode     = pwdata[0];
               REG_TX_LENGTH:     cfg.tx_length     = pwdata[LEN_W-1:0];
               REG_RX_LENGTH:     cfg.rx_length     = pwdata[LEN_W-1:0];
               default: ;
            endcase
         end
         // A result cannot belong to a request taken at the same edge, so check first.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: result %h with nothing expected", $time, rsp_data);
            end else begin
               oldest = awaited_results.pop_front();
               diff = "";
               if (rsp_data.set_mask !== oldest.set_mask)
                  diff = {diff, $sformatf(" set_mask %h/%h", oldest.set_mask, rsp_data.set_mask)};
               if (rsp_data.clear_mask !== oldest.clear_mask)
                  diff = {diff, $sformatf(" clear_mask %h/%h", oldest.clear_mask,
                                          rsp_data.clear_mask)};
               if (rsp_data.data_valid !== oldest.data_valid)
                  diff = {diff, $sformatf(" data_valid %b/%b", oldest.data_valid,
                                          rsp_data.data_valid)};
               if (rsp_data.data_out !== oldest.data_out)
                  diff = {diff, $sformatf(" data_out %h/%h", oldest.data_out, rsp_data.data_out)};
               if (rsp_data.ack_seen !== oldest.ack_seen)
                  diff = {diff, $sformatf(" ack_seen %b/%b", oldest.ack_seen, rsp_data.ack_seen)};
               if (rsp_data.rx_valid !== oldest.rx_valid)
                  diff = {diff, $sformatf(" rx_valid %b/%b", oldest.rx_valid, rsp_data.rx_valid)};
               if (rsp_data.rx_byte !== oldest.rx_byte)
                  diff = {diff, $sformatf(" rx_byte %h/%h", oldest.rx_byte, rsp_data.rx_byte)};
               if (rsp_data.rx_index !== oldest.rx_index)
                  diff = {diff, $sformatf(" rx_index %0d/%0d", oldest.rx_index, rsp_data.rx_index)};
               if (diff != "") begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: result mismatch, expected/actual:%s", $time, diff);
               end
            end
         end
         if (req_valid && !req_stall && sequence_status(req_data, prediction))
            awaited_results.push_back(prediction);
      end
      pending <= awaited_results.size();
   end

endmodule

>>> verif/tb.sv
// Top level of the I2C master status sequencer testbench: clock, reset, stimulus
// and verdict. Depends on i2cms_pkg, the sequencer RTL and i2cms_result_checker.
`timescale 1ns / 1ps

module tb;
   import i2cms_pkg::*;

   // Random items spread over this many configuration phases.
   localparam int ITEM_GOAL = 1550;
   localparam int PHASES    = 7;

   // Status codes the controller never reports; the block must swallow them.
   localparam logic [BYTE_W-1:0] UNUSED_CODE_HIGH = 8'hFF;
   localparam logic [BYTE_W-1:0] UNUSED_CODE_ODD  = 8'h59;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   req_type               req_data  = '0;
   logic                  rsp_stall = 1'b0;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;

   logic                  req_stall;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int unsigned mismatches;
   int unsigned pending;

   // Idling controls shared by the sender and the stall generator.
   bit          quiet      = 1'b0;
   int          gap_pct    = 30;
   int unsigned items_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   i2c_master_status_sequencer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   i2cms_result_checker status_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // Codes the controller can report; anything else is consumed without a result.
   function automatic bit known_code(input logic [BYTE_W-1:0] code);
      case (code)
         ST_BUS_ERROR, ST_START, ST_REP_START, ST_ADDR_W_ACK, ST_ADDR_W_NACK,
         ST_DATA_TX_ACK, ST_DATA_TX_NACK, ST_ARB_LOST, ST_ADDR_R_ACK,
         ST_ADDR_R_NACK, ST_DATA_RX_ACK, ST_DATA_RX_NACK: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] pick_code(input int k);
      case (k)
         0:       return ST_BUS_ERROR;
         1:       return ST_START;
         2:       return ST_REP_START;
         3:       return ST_ADDR_W_ACK;
         4:       return ST_ADDR_W_NACK;
         5:       return ST_DATA_TX_ACK;
         6:       return ST_DATA_TX_NACK;
         7:       return ST_ARB_LOST;
         8:       return ST_ADDR_R_ACK;
         9:       return ST_ADDR_R_NACK;
         10:      return ST_DATA_RX_ACK;
         default: return ST_DATA_RX_NACK;
      endcase
   endfunction

   // A status event. The load fields are don't-care here, so they carry noise.
   function automatic req_type status_req(input logic [BYTE_W-1:0] code);
      req_type r;
      r.action      = ACTION_STATUS;
      r.status_code = code;
      r.bus_data    = BYTE_W'($urandom);
      r.entry_index = ENTRY_W'($urandom);
      r.entry_value = BYTE_W'($urandom);
      return r;
   endfunction

   // A store load. The status fields are ignored by the block for loads.
   function automatic req_type load_req(input logic [ENTRY_W-1:0] idx,
                                        input logic [BYTE_W-1:0] value);
      req_type r;
      r.action      = ACTION_LOAD;
      r.status_code = BYTE_W'($urandom);
      r.bus_data    = BYTE_W'($urandom);
      r.entry_index = idx;
      r.entry_value = value;
      return r;
   endfunction

   // Presents one request and holds it until it is taken. Valid is left high so a
   // back-to-back request follows without a bubble; a gap may then drop it.
   task automatic send_request(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (item.action == ACTION_LOAD || known_code(item.status_code))
         items_sent++;
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every expected result has come back, then
   // gives loads and unknown codes still in the pipeline time to drain.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   // One register write: setup cycle, then access cycle until pready. The select is
   // dropped by program_registers, so consecutive writes need no idle cycle.
   task automatic csr_write(input logic [1:0] sel, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   // Writes all four registers; only called while the block is idle.
   task automatic program_registers(input logic [ADDR7_W-1:0] address,
                                    input logic               rd,
                                    input logic [LEN_W-1:0]   tx_len,
                                    input logic [LEN_W-1:0]   rx_len);
      csr_write(REG_SLAVE_ADDRESS, CSR_DATA_W'(address));
      csr_write(REG_READ_MODE, CSR_DATA_W'(rd));
      csr_write(REG_TX_LENGTH, CSR_DATA_W'(tx_len));
      csr_write(REG_RX_LENGTH, CSR_DATA_W'(rx_len));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // One bus transfer as the controller would report it. Most are well formed so
   // the counters advance deep into a transfer; the rest are loads and noise.
   task automatic run_transfer();
      int kind;
      int n;
      logic [BYTE_W-1:0] start_code;
      kind       = $urandom_range(0, 99);
      start_code = ($urandom_range(0, 3) == 0) ? ST_REP_START : ST_START;
      if (kind < 40) begin
         // Write transfer: address, then data bytes until the length runs out.
         send_request(status_req(start_code));
         if ($urandom_range(0, 19) == 0) begin
            send_request(status_req(ST_ARB_LOST));
            return;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_request(status_req(ST_ADDR_W_NACK));
            return;
         end
         send_request(status_req(ST_ADDR_W_ACK));
         n = $urandom_range(0, 10);
         repeat (n) begin
            if ($urandom_range(0, 11) == 0)
               send_request(load_req(ENTRY_W'($urandom), BYTE_W'($urandom)));
            send_request(status_req(ST_DATA_TX_ACK));
         end
         if ($urandom_range(0, 3) == 0)
            send_request(status_req(ST_DATA_TX_NACK));
      end else if (kind < 75) begin
         // Read transfer: bytes with ACK, the last one with NOT ACK.
         send_request(status_req(start_code));
         if ($urandom_range(0, 9) == 0) begin
            send_request(status_req(ST_ADDR_R_NACK));
            return;
         end
         send_request(status_req(ST_ADDR_R_ACK));
         n = $urandom_range(0, 9);
         repeat (n) send_request(status_req(ST_DATA_RX_ACK));
         send_request(status_req(ST_DATA_RX_NACK));
      end else if (kind < 82) begin
         // Run the transmit position past the store and the receive count into
         // saturation.
         send_request(status_req(start_code));
         n = $urandom_range(8, 12);
         repeat (n) send_request(status_req(ST_ADDR_W_ACK));
         n = $urandom_range(14, 18);
         repeat (n) send_request(status_req(ST_DATA_RX_ACK));
         send_request(status_req(ST_DATA_RX_NACK));
      end else if (kind < 90) begin
         n = $urandom_range(1, 4);
         repeat (n) send_request(load_req(ENTRY_W'($urandom), BYTE_W'($urandom)));
      end else begin
         // Broken sequences: codes out of order, unknown codes and stray loads.
         n = $urandom_range(1, 4);
         repeat (n) begin
            case ($urandom_range(0, 3))
               0:       send_request(status_req(BYTE_W'($urandom_range(0, 255))));
               1:       send_request(load_req(ENTRY_W'($urandom), BYTE_W'($urandom)));
               default: send_request(status_req(pick_code($urandom_range(0, 11))));
            endcase
         end
      end
   endtask

   // Result side back-pressure: random stall bursts between free stretches of
   // varying length. It goes silent once the quiet phase begins.
   initial begin
      int  n;
      bit  hold;
      @(posedge clock);
      forever begin
         hold = ($urandom_range(0, 2) == 0);
         n    = hold ? $urandom_range(1, 18) : $urandom_range(1, 60);
         repeat (n) begin
            rsp_stall <= hold && !quiet;
            @(posedge clock);
         end
      end
   end

   initial begin
      req_type r;
      int      target;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero lengths first: the address ACK still sends a byte, the next data ACK
      // stops, and the first received byte is answered with NOT ACK.
      program_registers(7'h7F, 1'b0, 4'd0, 4'd0);

      // Fill the whole store so no later read can hit an entry never written.
      send_request(load_req(3'd0, 8'h00));
      send_request(load_req(3'd1, 8'hFF));
      for (int i = 2; i < 8; i++)
         send_request(load_req(ENTRY_W'(i), BYTE_W'($urandom)));

      send_request(status_req(ST_START));
      send_request(status_req(ST_ADDR_W_ACK));
      send_request(status_req(ST_DATA_TX_ACK));
      send_request(status_req(ST_DATA_TX_NACK));
      send_request(status_req(ST_ADDR_W_NACK));
      send_request(status_req(ST_ADDR_R_NACK));
      send_request(status_req(ST_BUS_ERROR));
      send_request(status_req(ST_ARB_LOST));
      send_request(status_req(ST_REP_START));
      send_request(status_req(ST_ADDR_R_ACK));
      r = status_req(ST_DATA_RX_ACK);
      r.bus_data = 8'hFF;
      send_request(r);
      r = status_req(ST_DATA_RX_ACK);
      r.bus_data = 8'h00;
      send_request(r);
      send_request(status_req(ST_DATA_RX_NACK));
      send_request(status_req(UNUSED_CODE_HIGH));
      send_request(status_req(UNUSED_CODE_ODD));
      settle();

      // Random phases, each under its own register setting. The first two hold
      // the extremes; one phase runs without sender gaps, the last without any
      // idling at all.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       program_registers(7'h00, 1'b1, 4'd8, 4'd8);
            1:       program_registers(7'h7F, 1'b0, 4'd8, 4'd1);
            default: program_registers(ADDR7_W'($urandom_range(0, 127)),
                                       1'($urandom_range(0, 1)),
                                       LEN_W'($urandom_range(0, 8)),
                                       LEN_W'($urandom_range(0, 8)));
         endcase
         gap_pct = (phase == 2) ? 0 : $urandom_range(10, 60);
         quiet   = (phase == PHASES - 1);
         target  = items_sent + ITEM_GOAL / PHASES;
         while (items_sent < target) begin
            run_transfer();
            // Now and then let the result side catch up completely.
            if ($urandom_range(0, 99) < 3)
               settle();
         end
         settle();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("i2c_master_status_sequencer regression: pass");
      else
         $display("i2c_master_status_sequencer regression: fail");
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("i2c_master_status_sequencer regression: fail");
      $finish;
   end

endmodule

>>> files.f
rtl/i2cms_pkg.sv
rtl/i2cms_csr.sv
rtl/i2c_master_status_sequencer.sv
verif/i2cms_result_checker.sv
verif/tb.sv
